// ----- rtl/core/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Request codes, status codes and the command word broadcast along the
// row of list cells.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int POS_W  = 7;
    localparam int REQ_W  = 4;
    localparam int STAT_W = 3;
    localparam int VAL_W  = 32;

    localparam logic [REQ_W-1:0] REQ_PREPEND  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND   = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 4'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_AT   = 4'd5;
    localparam logic [REQ_W-1:0] REQ_REVERSE  = 4'd6;
    localparam logic [REQ_W-1:0] REQ_SEARCH   = 4'd7;
    localparam logic [REQ_W-1:0] REQ_READ_ALL = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [1:0] CMD_HOLD = 2'd0;
    localparam logic [1:0] CMD_INS  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;
    localparam logic [1:0] CMD_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] len;
    } cell_cmd_t;

endpackage

// ----- rtl/core/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// One list entry. Holds, loads the new word, or takes the word of its
// left neighbour, right neighbour or the head cell, as the command says.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  cell_cmd_t             cmd,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] head_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [POS_W-1:0] IDX_C  = POS_W'(IDX);
    localparam logic [POS_W-1:0] IDX_C1 = POS_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            CMD_INS: begin
                if (IDX_C > cmd.idx) begin
                    data_next = left_data;
                end else if (IDX_C == cmd.idx) begin
                    data_next = din;
                end
            end
            CMD_DEL: begin
                if (IDX_C >= cmd.idx) begin
                    data_next = right_data;
                end
            end
            CMD_ROT: begin
                if (IDX_C1 < cmd.len) begin
                    data_next = right_data;
                end else if (IDX_C1 == cmd.len) begin
                    data_next = head_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: decodes a request, drives the cell row, keeps the
// entry count, collects the result and holds the output register.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [VAL_W-1:0]  s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [VAL_W-1:0]  m_value_res,
    output logic [POS_W-1:0]         m_position_res,
    output logic [POS_W-1:0]         m_count,
    output logic                     m_last,
    input  logic [DATA_WIDTH-1:0]    head_data,
    output logic [DATA_WIDTH-1:0]    din,
    output cell_cmd_t                cmd
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_ROT    = 3'd2;
    localparam logic [2:0] S_DSHIFT = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         len_reg, len_next;
    logic [IW-1:0]         tgt_reg, tgt_next;
    logic                  found_reg, found_next;
    logic [STAT_W-1:0]     res_status_reg, res_status_next;
    logic [VAL_W-1:0]      res_val_reg, res_val_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;

    logic                  m_valid_reg;
    logic [STAT_W-1:0]     m_status_reg;
    logic [VAL_W-1:0]      m_value_reg;
    logic [POS_W-1:0]      m_pos_reg;
    logic [POS_W-1:0]      m_count_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic                  load_out;
    logic [STAT_W-1:0]     out_status;
    logic [VAL_W-1:0]      out_val;
    logic [POS_W-1:0]      out_pos;
    logic                  out_last;
    logic                  full;
    logic                  empty;
    logic                  bad_pos;
    logic                  rot_end;
    logic                  hit_now;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign bad_pos  = (pos_reg == '0) || (pos_reg > POS_W'(count_reg));
    assign rot_end  = (k_reg == count_reg - CW'(1));
    assign hit_now  = !found_reg && (head_data == val_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign din     = val_reg;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        tgt_next        = tgt_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_pos_next    = res_pos_reg;
        cmd.op          = CMD_HOLD;
        cmd.idx         = '0;
        cmd.len         = POS_W'(count_reg);
        load_out        = 1'b0;
        out_status      = res_status_reg;
        out_val         = res_val_reg;
        out_pos         = res_pos_reg;
        out_last        = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    pos_next   = s_position;
                    val_next   = DATA_WIDTH'(64'(s_value));
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = ST_OK;
                res_val_next    = '0;
                res_pos_next    = '0;
                k_next          = '0;
                len_next        = count_reg;
                found_next      = 1'b0;
                state_next      = S_FIN;
                case (req_reg)
                    REQ_PREPEND, REQ_APPEND, REQ_INSERT: begin
                        if (req_reg == REQ_INSERT && bad_pos) begin
                            res_status_next = ST_BADPOS;
                        end else if (full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            cmd.op     = CMD_INS;
                            count_next = count_reg + CW'(1);
                            if (req_reg == REQ_PREPEND) begin
                                cmd.idx = '0;
                            end else if (req_reg == REQ_APPEND) begin
                                cmd.idx = POS_W'(count_reg);
                            end else begin
                                cmd.idx = pos_reg - POS_W'(1);
                            end
                        end
                    end
                    REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_AT: begin
                        if (empty) begin
                            res_status_next = ST_EMPTY;
                        end else if (req_reg == REQ_DEL_AT && bad_pos) begin
                            res_status_next = ST_BADPOS;
                        end else begin
                            state_next = S_ROT;
                            if (req_reg == REQ_DEL_HEAD) begin
                                tgt_next = '0;
                            end else if (req_reg == REQ_DEL_TAIL) begin
                                tgt_next = IW'(count_reg - CW'(1));
                            end else begin
                                tgt_next = IW'(pos_reg - POS_W'(1));
                            end
                        end
                    end
                    REQ_REVERSE: begin
                        if (empty) begin
                            res_status_next = ST_EMPTY;
                        end else if (count_reg != CW'(1)) begin
                            state_next = S_ROT;
                        end
                    end
                    REQ_SEARCH: begin
                        if (empty) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_status_next = ST_NOTFOUND;
                            state_next      = S_ROT;
                        end
                    end
                    REQ_READ_ALL: begin
                        if (empty) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_ROT: begin
                cmd.op  = CMD_ROT;
                cmd.len = POS_W'(len_reg);
                k_next  = k_reg + CW'(1);
                if (req_reg == REQ_REVERSE) begin
                    len_next = len_reg - CW'(1);
                    if (len_reg == CW'(2)) begin
                        state_next = S_FIN;
                    end
                end else if (req_reg == REQ_SEARCH) begin
                    if (hit_now) begin
                        found_next      = 1'b1;
                        res_status_next = ST_OK;
                        res_val_next    = VAL_W'(head_data);
                        res_pos_next    = POS_W'(k_reg) + POS_W'(1);
                    end
                    if (rot_end) begin
                        state_next = S_FIN;
                    end
                end else begin
                    if (k_reg == CW'(tgt_reg)) begin
                        res_val_next = VAL_W'(head_data);
                    end
                    if (rot_end) begin
                        state_next = S_DSHIFT;
                    end
                end
            end
            S_DSHIFT: begin
                cmd.op     = CMD_DEL;
                cmd.idx    = POS_W'(tgt_reg);
                count_next = count_reg - CW'(1);
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                out_status = ST_OK;
                out_val    = VAL_W'(head_data);
                out_pos    = POS_W'(k_reg) + POS_W'(1);
                out_last   = rot_end;
                if (out_free) begin
                    load_out = 1'b1;
                    cmd.op   = CMD_ROT;
                    k_next   = k_reg + CW'(1);
                    if (rot_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        k_reg          <= k_next;
        len_reg        <= len_next;
        tgt_reg        <= tgt_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_pos_reg    <= res_pos_next;
        if (load_out) begin
            m_status_reg <= out_status;
            m_value_reg  <= out_val;
            m_pos_reg    <= out_pos;
            m_count_reg  <= POS_W'(count_reg);
            m_last_reg   <= out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_value_res    = m_value_reg;
    assign m_position_res = m_pos_reg;
    assign m_count        = m_count_reg;
    assign m_last         = m_last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_rot_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROT || state_reg == S_READ) |-> (k_reg < count_reg))
        else $error("rotation step beyond list length");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_FIN) |-> (cmd.op == CMD_HOLD))
        else $error("cell row moved outside a request");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid)
        else $error("result word lost");

endmodule

// ----- rtl/core/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed entries held in a row of cells.
//
// Requests arrive on the s_ valid/ready channel, one word per request;
// results leave on the m_ valid/ready channel, one word per request, or
// one word per entry for read all, m_last marking the final word.
// s_ready is high only while no request is in progress.
// Prepend, append, insert, unknown codes and every error or empty-list
// answer are decided without walking the list; deletes, search, reverse
// and read all step through it, each step one move of the whole cell
// row, and read all then loads one word a cycle while the output
// register is free. The next request is taken the cycle after the final
// word is loaded.
// A stalled receiver holds the output register and the sequencer waits
// in place; the list is never altered by a stall.
// Reset clears the entry count and empties the output register; entry
// contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [VAL_W-1:0]  s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [VAL_W-1:0]  m_value_res,
    output logic [POS_W-1:0]         m_position_res,
    output logic [POS_W-1:0]         m_count,
    output logic                     m_last
);

    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

    ple_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_value_res    (m_value_res),
        .m_position_res (m_position_res),
        .m_count        (m_count),
        .m_last         (m_last),
        .head_data      (cell_data[0]),
        .din            (din),
        .cmd            (cmd)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign right_w = '0;
        end else begin : g_next
            assign right_w = cell_data[i+1];
        end

        ple_cell #(
            .IDX        (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .din        (din),
            .head_data  (cell_data[0]),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives list requests into positional_list_engine and checks every result
// word against a behavioural copy of the list kept alongside. A short table
// covers empty-list answers, bad positions, extreme values and unused request
// codes. Random phases then grow the list to full, churn it and drain it,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import ple_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 80;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd9;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

    typedef enum int {GROW, CHURN, SHRINK} phase_t;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value_res;
        logic [POS_W-1:0]        position_res;
        logic [POS_W-1:0]        count;
        logic                    last;
    } answer_t;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        logic                    typed;
        logic [STAT_W-1:0]       status;
        logic [POS_W-1:0]        count;
    } plan_row_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type = '0;
    logic [POS_W-1:0]        s_position = '0;
    logic signed [VAL_W-1:0] s_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [STAT_W-1:0]       m_status;
    logic signed [VAL_W-1:0] m_value_res;
    logic [POS_W-1:0]        m_position_res;
    logic [POS_W-1:0]        m_count;
    logic                    m_last;

    logic signed [VAL_W-1:0] list_store [CAPACITY];
    int                      list_len = 0;
    answer_t                 pending_answers [$];
    int                      mismatch_count = 0;
    bit                      quiet = 1'b0;
    int                      idle_cycles = 0;
    int                      rx_hold = 0;

    positional_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VAL_W)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_value_res    (m_value_res),
        .m_position_res (m_position_res),
        .m_count        (m_count),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic add_answer(input logic [STAT_W-1:0] st, input logic signed [VAL_W-1:0] val,
                              input int pos, input bit last);
        answer_t a;
        a.status       = st;
        a.value_res    = val;
        a.position_res = pos[POS_W-1:0];
        a.count        = list_len[POS_W-1:0];
        a.last         = last;
        pending_answers.push_back(a);
    endtask

    task automatic model_request(input request_t rq);
        int i;
        int at;
        int pos;
        bit found;
        logic signed [VAL_W-1:0] t;
        pos = int'(rq.position);
        case (rq.req_type)
            REQ_PREPEND, REQ_APPEND, REQ_INSERT: begin
                if (rq.req_type == REQ_INSERT && (pos < 1 || pos > list_len)) begin
                    add_answer(ST_BADPOS, '0, 0, 1'b1);
                end else if (list_len >= CAPACITY) begin
                    add_answer(ST_FULL, '0, 0, 1'b1);
                end else begin
                    at = (rq.req_type == REQ_PREPEND) ? 0 :
                         (rq.req_type == REQ_APPEND) ? list_len : pos - 1;
                    for (i = list_len; i > at; i--)
                        list_store[i] = list_store[i-1];
                    list_store[at] = rq.value;
                    list_len++;
                    add_answer(ST_OK, '0, 0, 1'b1);
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_AT: begin
                if (list_len == 0) begin
                    add_answer(ST_EMPTY, '0, 0, 1'b1);
                end else if (rq.req_type == REQ_DEL_AT && (pos < 1 || pos > list_len)) begin
                    add_answer(ST_BADPOS, '0, 0, 1'b1);
                end else begin
                    at = (rq.req_type == REQ_DEL_HEAD) ? 0 :
                         (rq.req_type == REQ_DEL_TAIL) ? list_len - 1 : pos - 1;
                    t = list_store[at];
                    for (i = at; i + 1 < list_len; i++)
                        list_store[i] = list_store[i+1];
                    list_len--;
                    add_answer(ST_OK, t, 0, 1'b1);
                end
            end
            REQ_REVERSE: begin
                if (list_len == 0) begin
                    add_answer(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < list_len / 2; i++) begin
                        t = list_store[i];
                        list_store[i] = list_store[list_len-1-i];
                        list_store[list_len-1-i] = t;
                    end
                    add_answer(ST_OK, '0, 0, 1'b1);
                end
            end
            REQ_SEARCH: begin
                if (list_len == 0) begin
                    add_answer(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    found = 1'b0;
                    for (i = 0; i < list_len; i++) begin
                        if (!found && list_store[i] == rq.value) begin
                            found = 1'b1;
                            add_answer(ST_OK, list_store[i], i + 1, 1'b1);
                        end
                    end
                    if (!found)
                        add_answer(ST_NOTFOUND, '0, 0, 1'b1);
                end
            end
            REQ_READ_ALL: begin
                if (list_len == 0) begin
                    add_answer(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < list_len; i++)
                        add_answer(ST_OK, list_store[i], i + 1, i == list_len - 1);
                end
            end
            default: add_answer(ST_OK, '0, 0, 1'b1);
        endcase
    endtask

    function automatic request_t draw_request(input phase_t ph);
        request_t rq;
        int r;
        int p;
        int v;
        r = $urandom_range(0, 99);
        case (ph)
            GROW: begin
                if (r < 25)      rq.req_type = REQ_PREPEND;
                else if (r < 50) rq.req_type = REQ_APPEND;
                else if (r < 70) rq.req_type = REQ_INSERT;
                else if (r < 73)
                    rq.req_type = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                else
                    rq.req_type = REQ_W'($urandom_range(REQ_DEL_HEAD, REQ_READ_ALL));
            end
            SHRINK: begin
                if (r < 20)      rq.req_type = REQ_DEL_HEAD;
                else if (r < 40) rq.req_type = REQ_DEL_TAIL;
                else if (r < 62) rq.req_type = REQ_DEL_AT;
                else if (r < 65)
                    rq.req_type = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                else
                    rq.req_type = REQ_W'($urandom_range(REQ_PREPEND, REQ_READ_ALL));
            end
            default: begin
                if (r < 5)
                    rq.req_type = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                else
                    rq.req_type = REQ_W'($urandom_range(REQ_PREPEND, REQ_READ_ALL));
            end
        endcase
        p = $urandom_range(0, 9);
        if (p < 7 && list_len > 0) rq.position = POS_W'($urandom_range(1, list_len));
        else if (p < 7)            rq.position = '0;
        else if (p == 7)           rq.position = '0;
        else if (p == 8)           rq.position = POS_W'(list_len + 1);
        else                       rq.position = POS_W'($urandom_range(0, 127));
        v = $urandom_range(0, 9);
        if (v < 4 && list_len > 0) begin
            rq.value = list_store[$urandom_range(0, list_len - 1)];
        end else if (v == 4) begin
            case ($urandom_range(0, 3))
                0: rq.value = 32'sh8000_0000;
                1: rq.value = 32'sh7fff_ffff;
                2: rq.value = '0;
                default: rq.value = -32'sd1;
            endcase
        end else if (v == 5) begin
            rq.value = $urandom_range(0, 7);
        end else begin
            rq.value = $urandom;
        end
        return rq;
    endfunction

    task automatic send_request(input request_t rq);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rq.req_type;
        s_position <= rq.position;
        s_value    <= rq.value;
        do @(posedge aclk); while (!s_ready);
        model_request(rq);
    endtask

    task automatic wait_for_drain();
        do @(posedge aclk); while (pending_answers.size() != 0);
    endtask

    // result side: random stalls and word-by-word compare
    always @(posedge aclk) begin : receiver
        answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    $error("unexpected result word: status %0d value %0d", m_status, m_value_res);
                    mismatch_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatch_count++;
                    end
                    if (m_value_res !== want.value_res) begin
                        $error("value_res: expected %0d, got %0d", want.value_res, m_value_res);
                        mismatch_count++;
                    end
                    if (m_position_res !== want.position_res) begin
                        $error("position_res: expected %0d, got %0d",
                               want.position_res, m_position_res);
                        mismatch_count++;
                    end
                    if (m_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, m_count);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        mismatch_count++;
                    end
                end
                rx_hold = quiet ? 0 : $urandom_range(0, 5);
            end
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        plan_row_t plan [25];
        request_t  rq;
        answer_t   typed_answer;
        phase_t    ph;
        int        sent;
        int        n;
        int        extra;
        bit        done;
        plan = '{
            '{REQ_DEL_HEAD,  7'd0,   32'sd0,          1'b1, ST_EMPTY,    7'd0},
            '{REQ_DEL_TAIL,  7'd0,   32'sd0,          1'b1, ST_EMPTY,    7'd0},
            '{REQ_DEL_AT,    7'd1,   32'sd0,          1'b1, ST_EMPTY,    7'd0},
            '{REQ_REVERSE,   7'd0,   32'sd0,          1'b1, ST_EMPTY,    7'd0},
            '{REQ_SEARCH,    7'd0,   32'sd0,          1'b1, ST_EMPTY,    7'd0},
            '{REQ_READ_ALL,  7'd0,   32'sd0,          1'b1, ST_EMPTY,    7'd0},
            '{REQ_INSERT,    7'd1,   32'sd5,          1'b1, ST_BADPOS,   7'd0},
            '{REQ_UNUSED_HI, 7'd0,   32'sd0,          1'b1, ST_OK,       7'd0},
            '{REQ_APPEND,    7'd0,   32'sh7fff_ffff,  1'b1, ST_OK,       7'd1},
            '{REQ_PREPEND,   7'd127, 32'sh8000_0000,  1'b1, ST_OK,       7'd2},
            '{REQ_INSERT,    7'd2,   -32'sd1,         1'b1, ST_OK,       7'd3},
            '{REQ_INSERT,    7'd0,   32'sd9,          1'b1, ST_BADPOS,   7'd3},
            '{REQ_INSERT,    7'd4,   32'sd9,          1'b1, ST_BADPOS,   7'd3},
            '{REQ_INSERT,    7'd127, 32'sd9,          1'b1, ST_BADPOS,   7'd3},
            '{REQ_DEL_AT,    7'd0,   32'sd0,          1'b1, ST_BADPOS,   7'd3},
            '{REQ_DEL_AT,    7'd4,   32'sd0,          1'b1, ST_BADPOS,   7'd3},
            '{REQ_DEL_AT,    7'd127, 32'sd0,          1'b1, ST_BADPOS,   7'd3},
            '{REQ_SEARCH,    7'd0,   32'sh7fff_ffff,  1'b0, ST_OK,       7'd0},
            '{REQ_SEARCH,    7'd0,   32'sd0,          1'b1, ST_NOTFOUND, 7'd3},
            '{REQ_REVERSE,   7'd0,   32'sd0,          1'b1, ST_OK,       7'd3},
            '{REQ_READ_ALL,  7'd0,   32'sd0,          1'b0, ST_OK,       7'd0},
            '{REQ_DEL_AT,    7'd2,   32'sd0,          1'b0, ST_OK,       7'd0},
            '{REQ_DEL_HEAD,  7'd0,   32'sd0,          1'b0, ST_OK,       7'd0},
            '{REQ_DEL_TAIL,  7'd0,   32'sd0,          1'b0, ST_OK,       7'd0},
            '{REQ_UNUSED_LO, 7'd0,   32'sd0,          1'b1, ST_OK,       7'd0}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[k]) begin
            rq.req_type = plan[k].req_type;
            rq.position = plan[k].position;
            rq.value    = plan[k].value;
            send_request(rq);
            if (plan[k].typed) begin
                void'(pending_answers.pop_back());
                typed_answer.status       = plan[k].status;
                typed_answer.value_res    = 32'sd0;
                typed_answer.position_res = 7'd0;
                typed_answer.count        = plan[k].count;
                typed_answer.last         = 1'b1;
                pending_answers.push_back(typed_answer);
            end
        end
        s_valid <= 1'b0;
        wait_for_drain();

        // grow to full, churn, drain to empty if more than half full else grow again, churn, and round again
        sent = 0;
        ph = GROW;
        while (sent < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            n = 0;
            extra = 0;
            done = 1'b0;
            while (!done) begin
                send_request(draw_request(ph));
                n++;
                sent++;
                case (ph)
                    GROW:    if (list_len == CAPACITY) extra++;
                    SHRINK:  if (list_len == 0) extra++;
                    default: extra++;
                endcase
                done = (ph == CHURN ? extra >= 30 : extra >= 8) || n >= 150
                       || sent >= RANDOM_ITEMS;
            end
            s_valid <= 1'b0;
            wait_for_drain();
            case (ph)
                GROW:    ph = CHURN;
                CHURN:   ph = (list_len > CAPACITY / 2) ? SHRINK : GROW;
                default: ph = CHURN;
            endcase
        end
        quiet = 1'b0;

        wait_for_drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
